// File: src/discrete_alias_sampler_defines.svh
// Assertion macros for the discrete alias sampler.
// Depends on nothing; taken in by discrete_alias_sampler, the module that asserts.
`ifndef DISCRETE_ALIAS_SAMPLER_DEFINES_SVH
`define DISCRETE_ALIAS_SAMPLER_DEFINES_SVH
`ifndef SYNTH
`define DAS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("das assertion failed");
`define DAS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("das assertion failed");
`else
`define DAS_ASSERT(lbl, clk, rstn, prop)
`define DAS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: src/das_pkg.sv
// Package for the discrete alias sampler: beat types, codes, widths.
// No dependencies.
package das_pkg;
    localparam int SLOTS       = 64;
    localparam int IDX_W       = 6;
    localparam int WGT_W       = 32;
    localparam int TOT_W       = 38;
    localparam int BAR_W       = 60;
    localparam int THR_W       = 64;
    localparam int FRAC_BITS   = 53;
    localparam int THR_SHIFT   = 11;
    localparam int SCALE_STEPS = 59;
    localparam int DEF_NUM_SYMBOLS = 64;
    localparam int DEF_WEIGHT_BITS = 32;
    localparam logic [BAR_W-1:0] BAR_ONE = BAR_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_BUILT    = 2'd0,
        ST_DRAWN    = 2'd1,
        ST_ZERO     = 2'd2,
        ST_NOTBUILT = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] symbol_index;
        logic [WGT_W-1:0] weight;
        logic [63:0]      random_word;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] symbol;
    } t_out_beat;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [IDX_W-1:0] alias_idx;
    } t_tab_entry;
endpackage

// File: src/das_div.sv
// Bit-serial restoring divider: floor(w * 2^59 / total), w <= total.
// Depends on das_pkg.
module das_div
    import das_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TOT_W-1:0] i_dividend,
    input  logic [TOT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [BAR_W-1:0] o_quot
);
    logic [TOT_W-1:0] r_rem;
    logic [TOT_W-1:0] r_den;
    logic [BAR_W-1:0] r_quot;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [TOT_W:0]   rem2;
    logic             ge;
    logic             q0;

    assign q0   = i_dividend >= i_divisor;
    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_divisor;
                r_quot <= BAR_W'(q0);
                r_rem  <= q0 ? (i_dividend - i_divisor) : i_dividend;
            end else if (r_busy) begin
                r_rem  <= ge ? TOT_W'(rem2 - {1'b0, r_den}) : TOT_W'(rem2);
                r_quot <= {r_quot[BAR_W-2:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(SCALE_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: src/discrete_alias_sampler.sv
// Walker alias table builder and sampler over 64 slots.
// Depends on das_pkg, das_div and discrete_alias_sampler_defines.svh.
//
//   channel | valid      | ready       | beat
//   in      | i_in_valid | o_in_ready  | i_in_data  (t_in_beat)
//   out     | o_out_valid| i_out_ready | o_out_data (t_out_beat)
//
// Load: weight memory write. Sample: table memory read, compare, result register.
// Build: summing pass, then per-slot scaling through the bit-serial divider
// (59 steps per slot), then pairing and finishing scans.
// Reset is synchronous; weights read as zero until written, no clearing pass.
// Input is taken only between items; a result waiting at the output does
// not block loads.
`include "discrete_alias_sampler_defines.svh"
module discrete_alias_sampler
    import das_pkg::*;
#(
    parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);
    localparam logic [WGT_W-1:0] WMASK = (WEIGHT_BITS >= WGT_W) ? '1 :
        WGT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SUM   = 13'b0000000000010,
        S_SRD   = 13'b0000000000100,
        S_SLD   = 13'b0000000001000,
        S_SDIV  = 13'b0000000010000,
        S_SCANM = 13'b0000000100000,
        S_SCANG = 13'b0000001000000,
        S_PRD   = 13'b0000010000000,
        S_PWR   = 13'b0000100000000,
        S_FING  = 13'b0001000000000,
        S_FINM  = 13'b0010000000000,
        S_SMP   = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state           r_st;
    logic [6:0]       r_k, r_g, r_m, r_mm;
    logic             r_pend;
    logic [TOT_W-1:0] r_tot;
    logic             r_ready;
    logic [SLOTS-1:0] r_wvalid, r_big, r_le;
    logic [63:0]      r_u;
    t_out_beat        r_res, r_out;
    logic             r_ov;

    logic [WGT_W-1:0] wmem [SLOTS];
    logic [BAR_W-1:0] bmem [SLOTS];
    t_tab_entry       tmem [SLOTS];
    logic [WGT_W-1:0] r_wrd;
    logic             r_wv;
    logic [BAR_W-1:0] r_bm, r_bg;
    t_tab_entry       r_tab;

    logic             in_acc;
    logic             w_we;
    logic [WGT_W-1:0] w_eff;
    logic [TOT_W-1:0] tot_fin;
    logic             b_we;
    logic [IDX_W-1:0] b_wa;
    logic [BAR_W-1:0] b_wd, bar_new;
    logic             t_we;
    logic [IDX_W-1:0] t_wa;
    t_tab_entry       t_wd;
    logic             div_start, div_done;
    logic [BAR_W-1:0] div_q;
    logic             m_in, g_in;

    assign in_acc  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_st == S_IDLE);
    assign w_we    = in_acc && (i_in_data.mode == MODE_LOAD) &&
                     ({1'b0, i_in_data.symbol_index} < 7'(NUM_SYMBOLS));
    assign w_eff   = r_wv ? r_wrd : '0;
    assign tot_fin = r_tot + TOT_W'(w_eff);
    assign bar_new = r_bg + r_bm - BAR_ONE;
    assign m_in    = r_m < 7'(SLOTS);
    assign g_in    = r_g < 7'(SLOTS);
    assign div_start = (r_st == S_SLD);

    das_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (TOT_W'(w_eff)),
        .i_divisor  (r_tot),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        b_we = 1'b0;
        b_wa = r_k[IDX_W-1:0];
        b_wd = div_q;
        t_we = 1'b0;
        t_wa = r_m[IDX_W-1:0];
        t_wd = '{thr: '1, alias_idx: r_m[IDX_W-1:0]};
        case (r_st)
            S_SDIV: b_we = div_done;
            S_PWR: begin
                b_we = 1'b1;
                b_wa = r_g[IDX_W-1:0];
                b_wd = bar_new;
                t_we = 1'b1;
                t_wd = '{thr: {r_bm[THR_W-THR_SHIFT-1:0], {THR_SHIFT{1'b0}}},
                         alias_idx: r_g[IDX_W-1:0]};
            end
            S_FING: begin
                if (g_in) begin
                    t_we = r_big[r_g[IDX_W-1:0]];
                    t_wa = r_g[IDX_W-1:0];
                    t_wd = '{thr: '1, alias_idx: r_g[IDX_W-1:0]};
                end else begin
                    t_we = m_in;
                end
            end
            S_FINM: t_we = m_in && r_le[r_m[IDX_W-1:0]];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wmem[i_in_data.symbol_index] <= i_in_data.weight & WMASK;
        end
        r_wrd <= wmem[r_k[IDX_W-1:0]];
        r_wv  <= r_wvalid[r_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            bmem[b_wa] <= b_wd;
        end
        r_bm <= bmem[r_m[IDX_W-1:0]];
        r_bg <= bmem[r_g[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tmem[t_wa] <= t_wd;
        end
        r_tab <= tmem[i_in_data.random_word[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ready  <= 1'b0;
            r_wvalid <= '0;
            r_ov     <= 1'b0;
            r_tot    <= '0;
            r_k      <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && (r_st != S_RESP)) begin
                r_ov <= 1'b0;
            end
            if (w_we) begin
                r_wvalid[i_in_data.symbol_index] <= 1'b1;
            end
            if (b_we) begin
                r_big[b_wa] <= b_wd >= BAR_ONE;
                r_le[b_wa]  <= b_wd <= BAR_ONE;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_u <= i_in_data.random_word;
                        case (i_in_data.mode)
                            MODE_BUILD: begin
                                r_k    <= '0;
                                r_pend <= 1'b0;
                                r_tot  <= '0;
                                r_st   <= S_SUM;
                            end
                            MODE_SAMPLE: begin
                                if (r_ready) begin
                                    r_st <= S_SMP;
                                end else begin
                                    r_res <= '{status: ST_NOTBUILT, symbol: '0};
                                    r_st  <= S_RESP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    if (r_pend) begin
                        r_tot <= tot_fin;
                    end
                    if (r_k == 7'(SLOTS)) begin
                        r_k <= '0;
                        if (tot_fin == '0) begin
                            r_ready <= 1'b0;
                            r_res   <= '{status: ST_ZERO, symbol: '0};
                            r_st    <= S_RESP;
                        end else begin
                            r_st <= S_SRD;
                        end
                    end else begin
                        r_k    <= r_k + 7'd1;
                        r_pend <= 1'b1;
                    end
                end
                S_SRD: r_st <= S_SLD;
                S_SLD: r_st <= S_SDIV;
                S_SDIV: begin
                    if (div_done) begin
                        if (r_k == 7'(SLOTS - 1)) begin
                            r_m  <= '0;
                            r_g  <= '0;
                            r_st <= S_SCANM;
                        end else begin
                            r_k  <= r_k + 7'd1;
                            r_st <= S_SRD;
                        end
                    end
                end
                S_SCANM: begin
                    if (m_in && r_big[r_m[IDX_W-1:0]]) begin
                        r_m <= r_m + 7'd1;
                    end else begin
                        r_mm <= r_m + 7'd1;
                        r_st <= S_SCANG;
                    end
                end
                S_SCANG: begin
                    if (g_in && !r_big[r_g[IDX_W-1:0]]) begin
                        r_g <= r_g + 7'd1;
                    end else if (g_in && m_in) begin
                        r_st <= S_PRD;
                    end else begin
                        r_st <= S_FING;
                    end
                end
                S_PRD: r_st <= S_PWR;
                S_PWR: begin
                    if (bar_new >= BAR_ONE || r_mm <= r_g) begin
                        r_m  <= r_mm;
                        r_st <= S_SCANM;
                    end else begin
                        r_m  <= r_g;
                        r_st <= S_SCANG;
                    end
                end
                S_FING: begin
                    if (g_in) begin
                        r_g <= r_g + 7'd1;
                    end else if (m_in) begin
                        r_m  <= r_mm;
                        r_st <= S_FINM;
                    end else begin
                        r_ready <= 1'b1;
                        r_res   <= '{status: ST_BUILT, symbol: '0};
                        r_st    <= S_RESP;
                    end
                end
                S_FINM: begin
                    if (m_in) begin
                        r_m <= r_m + 7'd1;
                    end else begin
                        r_ready <= 1'b1;
                        r_res   <= '{status: ST_BUILT, symbol: '0};
                        r_st    <= S_RESP;
                    end
                end
                S_SMP: begin
                    r_res <= '{status: ST_DRAWN,
                               symbol: (r_u < r_tab.thr) ? r_u[IDX_W-1:0] : r_tab.alias_idx};
                    r_st  <= S_RESP;
                end
                S_RESP: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov  <= 1'b1;
                        r_out <= r_res;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `DAS_ASSERT(a_pair_roles, i_clk, i_rst_n,
        (r_st == S_PWR) |-> (!r_big[r_m[IDX_W-1:0]] && r_big[r_g[IDX_W-1:0]] && m_in && g_in))
    `DAS_ASSERT(a_drawn_needs_table, i_clk, i_rst_n,
        (r_st == S_SMP) |=> (r_res.status == ST_DRAWN && r_ready))
    `DAS_ASSERT(a_sum_bound, i_clk, i_rst_n, (r_st == S_SUM) |-> (r_k <= 7'(SLOTS)))
    `DAS_ASSERT(a_div_in_scale, i_clk, i_rst_n, div_done |-> (r_st == S_SDIV))
endmodule

// File: test/discrete_alias_sampler_tb.sv
// Testbench for discrete_alias_sampler: directed and random beats of every mode checked
// against an in-bench alias table predictor. Depends on das_pkg and the RTL.
`timescale 1ns / 1ps
module discrete_alias_sampler_tb;
    import das_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    discrete_alias_sampler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0]      wt_mem [SLOTS];
    logic [63:0]      thr_mem [SLOTS];
    logic [IDX_W-1:0] alias_mem [SLOTS];
    logic [59:0]      bar [SLOTS];
    bit               built;

    t_in_beat  pending_q [$];
    t_out_beat expected_q [$];
    int        errors = 0;
    bit        stim_done = 0;
    bit        no_idle = 0;
    bit        sender_hold = 0;
    int        rx_hold = 0;
    int        rx_hold_req = 0;

    function automatic logic [59:0] bar_of(logic [63:0] w, logic [63:0] tot);
        logic [127:0] num;
        num = {64'd0, w} << 59;
        return 60'(num / {64'd0, tot});
    endfunction

    task automatic build_alias();
        int g, m, mm, k;
        for (k = 0; k < SLOTS; k++) bar[k] = 60'd0;
        begin
            logic [63:0] tot;
            tot = 0;
            for (k = 0; k < SLOTS; k++) tot += wt_mem[k];
            for (k = 0; k < SLOTS; k++) bar[k] = bar_of(wt_mem[k], tot);
        end
        for (g = 0; g < SLOTS && bar[g] < BAR_ONE; g++) ;
        for (m = 0; m < SLOTS && bar[m] >= BAR_ONE; m++) ;
        mm = m + 1;
        while (g < SLOTS && m < SLOTS) begin
            thr_mem[m] = {4'd0, bar[m]} << THR_SHIFT;
            alias_mem[m] = IDX_W'(g);
            bar[g] = bar[g] + bar[m] - BAR_ONE;
            if (bar[g] >= BAR_ONE || mm <= g) begin
                for (m = mm; m < SLOTS && bar[m] >= BAR_ONE; m++) ;
                mm = m + 1;
            end else begin
                m = g;
            end
            for (; g < SLOTS && bar[g] < BAR_ONE; g++) ;
        end
        for (; g < SLOTS; g++)
            if (bar[g] >= BAR_ONE) begin
                thr_mem[g] = '1; alias_mem[g] = IDX_W'(g);
            end
        if (m < SLOTS) begin
            thr_mem[m] = '1; alias_mem[m] = IDX_W'(m);
            for (m = mm; m < SLOTS; m++)
                if (bar[m] <= BAR_ONE) begin
                    thr_mem[m] = '1; alias_mem[m] = IDX_W'(m);
                end
        end
    endtask

    task automatic predict_beat(t_in_beat b);
        t_out_beat r;
        logic [63:0] tot;
        logic [5:0] x;
        r = '0;
        case (t_mode'(b.mode))
            MODE_LOAD: wt_mem[b.symbol_index] = b.weight;
            MODE_BUILD: begin
                tot = 0;
                for (int k = 0; k < SLOTS; k++) tot += wt_mem[k];
                if (tot == 0) begin
                    built = 0; r.status = ST_ZERO;
                end else begin
                    build_alias(); built = 1; r.status = ST_BUILT;
                end
                expected_q.push_back(r);
            end
            MODE_SAMPLE: begin
                if (!built) begin
                    r.status = ST_NOTBUILT;
                end else begin
                    x = b.random_word[5:0];
                    r.status = ST_DRAWN;
                    r.symbol = (b.random_word < thr_mem[x]) ? x : alias_mem[x];
                end
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic t_in_beat mk(t_mode md, int idx, logic [31:0] w, logic [63:0] u);
        t_in_beat b;
        b.mode = md; b.symbol_index = IDX_W'(idx); b.weight = w; b.random_word = u;
        return b;
    endfunction

    function automatic logic [31:0] rnd_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rnd_word();
        return {$urandom, $urandom};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_beat(i_in_data);
                void'(pending_q.pop_front());
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_q.size() > (i_in_valid && o_in_ready ? 0 : 0) && !sender_hold
                    && (no_idle || $urandom_range(0, 99) >= 17)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected beat: expected none, actual %p", $time, o_out_data);
                    errors++;
                end else begin
                    t_out_beat e;
                    e = expected_q.pop_front();
                    if (e.status !== o_out_data.status)
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, e.status, o_out_data.status);
                    if (e.symbol !== o_out_data.symbol)
                        $display("%0t symbol mismatch: expected %0d, actual %0d",
                                 $time, e.symbol, o_out_data.symbol);
                    if (e !== o_out_data) errors++;
                end
            end
            if (rx_hold_req > 0) begin
                rx_hold <= rx_hold_req;
                rx_hold_req <= 0;
                i_out_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || $urandom_range(0, 99) >= 17;
            end
        end
    end

    // pending_q[0] is the beat on the bus; wait until queue drains
    task automatic wait_sent();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        wait_sent();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_set(int kind);
        int n;
        for (int k = 0; k < SLOTS; k++) begin
            logic [31:0] w;
            case (kind)
                0: w = rnd_weight();
                1: w = ($urandom_range(0, 3) == 0) ? rnd_weight() : 32'd0;
                2: w = $urandom_range(1, 1000);
                default: w = 32'd1;
            endcase
            pending_q.push_back(mk(MODE_LOAD, k, w, rnd_word()));
        end
        pending_q.push_back(mk(MODE_BUILD, 0, 0, 0));
        n = $urandom_range(10, 40);
        for (int k = 0; k < n; k++)
            pending_q.push_back(mk(MODE_SAMPLE, $urandom, $urandom, rnd_word()));
    endtask

    initial begin
        int total;
        for (int k = 0; k < SLOTS; k++) wt_mem[k] = 0;
        built = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, '1));
        pending_q.push_back(mk(MODE_BUILD, 0, 0, 0));
        pending_q.push_back(mk(MODE_NONE, 63, '1, '1));
        pending_q.push_back(mk(MODE_LOAD, 63, 32'hFFFF_FFFF, 0));
        pending_q.push_back(mk(MODE_LOAD, 0, 32'd1, 0));
        pending_q.push_back(mk(MODE_BUILD, 0, 0, 0));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, 64'd0));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, '1));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, 64'h0000_0000_0000_003F));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, 64'hFFFF_FFFF_FFFF_FFC0));
        pending_q.push_back(mk(MODE_LOAD, 5, 32'd7, 0));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, 64'h8000_0000_0000_0005));
        pending_q.push_back(mk(MODE_LOAD, 0, 0, 0));
        pending_q.push_back(mk(MODE_LOAD, 5, 0, 0));
        pending_q.push_back(mk(MODE_LOAD, 63, 0, 0));
        pending_q.push_back(mk(MODE_BUILD, 0, 0, 0));
        pending_q.push_back(mk(MODE_SAMPLE, 0, 0, 64'd3));
        wait_drain();
        // uniform table, then long receiver stall with samples queued
        load_set(3);
        wait_drain();
        rx_hold_req = 400;
        for (int k = 0; k < 60; k++)
            pending_q.push_back(mk(MODE_SAMPLE, 0, 0, rnd_word()));
        wait_drain();
        sender_hold = 1;
        repeat (20) @(posedge i_clk);
        sender_hold = 0;
        // random sets
        total = 0;
        while (total < 1700) begin
            int kind;
            kind = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 5) == 0);
            load_set(kind);
            total += pending_q.size();
            if ($urandom_range(0, 3) == 0)
                pending_q.push_back(mk(t_mode'($urandom_range(0, 3)), $urandom, $urandom,
                                       rnd_word()));
            wait_sent();
        end
        no_idle = 0;
        wait_drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("discrete_alias_sampler test passed");
        else
            $display("discrete_alias_sampler test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("discrete_alias_sampler test failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/das_pkg.sv
src/das_div.sv
src/discrete_alias_sampler.sv
test/discrete_alias_sampler_tb.sv
